// ===== rtl/core/bsort_pkg.sv =====
// Package of shared constants for the bucket sort core.
`default_nettype none
package bsort_pkg;
    localparam int MAX_ITEMS_DEF   = 64;
    localparam int MAX_BUCKETS_DEF = 16;
    localparam int VAL_W           = 17;
    localparam int BCNT_W          = 5;
    localparam int PADDR_W         = 3;
    localparam logic [BCNT_W-1:0] BCNT_RST  = 5'd16;
    localparam logic [VAL_W-1:0]  BWIDTH_RST = 17'd6250;
    localparam logic REG_BCNT   = 1'b0;
    localparam logic REG_BWIDTH = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/core/bsort_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bsort_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/bucket_sort_core.sv =====
// Top level of the bucket sort core: load, bucket tagging, in-memory insertion, readout.
`default_nettype none
// Values arrive one transaction at a time and are kept in one RAM as {bucket, value}
// keys, held in ascending key order, so the readout is bucket by bucket and ascending
// within each bucket. An accepted value first gets its bucket by repeated addition of
// the bucket width, then is inserted by walking the RAM downward, one read-compare-write
// per cycle. A value arriving with the store full is dropped and sets the overflow flag,
// which rides on every result of that run. On the transaction marked last, all stored
// values are read out, each result via ST_ORD then ST_OCAP (which waits while the
// result register is full), the final one flagged; the store, count and flag are then
// clear for the next set. The result register decouples the sides: the next set may
// start loading while the final result still waits. Configuration: bucket_count at
// address 0, bucket_width at address 4.
module bucket_sort_core #(
    parameter int MAX_ITEMS   = bsort_pkg::MAX_ITEMS_DEF,
    parameter int MAX_BUCKETS = bsort_pkg::MAX_BUCKETS_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [bsort_pkg::PADDR_W-1:0]    paddr,
    input  wire [31:0]                      pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire [bsort_pkg::VAL_W-1:0]      s_value,
    input  wire                             s_last,
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic [bsort_pkg::VAL_W-1:0]     m_sorted_value,
    output logic                            m_final_res,
    output logic                            m_overflow
);
    localparam int VW  = bsort_pkg::VAL_W;
    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int TW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int KW  = TW + VW;
    localparam int ACW = VW + 2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_RD, ST_CMP, ST_KEY0, ST_ORD, ST_OCAP
    } state_t;

    state_t              state_reg;
    logic [4:0]          bcnt_reg;
    logic [VW-1:0]       bwidth_reg;
    logic [VW-1:0]       val_reg;
    logic                last_reg;
    logic [TW-1:0]       k_reg;
    logic [ACW-1:0]      acc_reg;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       pos_reg;
    logic [AW-1:0]       o_reg;
    logic                flag_reg;

    logic                we;
    logic [AW-1:0]       waddr;
    logic [KW-1:0]       wdata;
    logic [AW-1:0]       raddr;
    logic [KW-1:0]       rdata;
    logic [KW-1:0]       key;
    logic [6:0]          nb_used;
    logic [TW-1:0]       nb_m1;
    logic [ACW-1:0]      width_eff;
    logic                cfg_wr;
    logic                is_final;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign s_ready = (state_reg == ST_IDLE);
    assign key     = {k_reg, val_reg};
    assign is_final = (o_reg == AW'(cnt_reg - CW'(1)));

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == bsort_pkg::REG_BWIDTH) begin
            prdata[VW-1:0] = bwidth_reg;
        end else begin
            prdata[4:0] = bcnt_reg;
        end
    end

    // Clamp the bucket count into 1..MAX_BUCKETS; width zero acts as one.
    always_comb begin
        if (bcnt_reg == 5'd0) begin
            nb_used = 7'd1;
        end else if ({2'b00, bcnt_reg} > 7'(MAX_BUCKETS)) begin
            nb_used = 7'(MAX_BUCKETS);
        end else begin
            nb_used = {2'b00, bcnt_reg};
        end
        nb_m1 = TW'(nb_used - 7'd1);
        width_eff = (bwidth_reg == '0) ? ACW'(1) : {2'b00, bwidth_reg};
    end

    // RAM port control: insertion walk and readout.
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = key;
        raddr = o_reg;
        case (state_reg)
            ST_RD: begin
                if (cnt_reg == '0) begin
                    we = 1'b1;
                end else begin
                    raddr = AW'(cnt_reg - CW'(1));
                end
            end
            ST_CMP: begin
                we    = 1'b1;
                waddr = pos_reg[AW-1:0];
                if (rdata > key) begin
                    wdata = rdata;
                    raddr = AW'(pos_reg - CW'(2));
                end
            end
            ST_KEY0: begin
                we = 1'b1;
            end
            default: begin
                raddr = o_reg;
            end
        endcase
    end

    bsort_ram #(.WIDTH(KW), .DEPTH(MAX_ITEMS)) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            bcnt_reg   <= bsort_pkg::BCNT_RST;
            bwidth_reg <= bsort_pkg::BWIDTH_RST;
            cnt_reg    <= '0;
            flag_reg   <= 1'b0;
            m_valid    <= 1'b0;
            o_reg      <= '0;
            pos_reg    <= '0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == bsort_pkg::REG_BCNT) begin
                    bcnt_reg <= pwdata[4:0];
                end else begin
                    bwidth_reg <= pwdata[VW-1:0];
                end
            end
            // Drop the result once taken; during readout the capture below decides.
            if (m_ready && state_reg != ST_OCAP) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        last_reg <= s_last;
                        o_reg    <= '0;
                        if (cnt_reg == CW'(MAX_ITEMS)) begin
                            flag_reg <= 1'b1;
                            if (s_last) begin
                                state_reg <= ST_ORD;
                            end
                        end else begin
                            val_reg   <= s_value;
                            k_reg     <= '0;
                            acc_reg   <= width_eff;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    // Advance the bucket while the next boundary is not above the value.
                    if (k_reg < nb_m1 && acc_reg <= {2'b00, val_reg}) begin
                        k_reg   <= k_reg + TW'(1);
                        acc_reg <= acc_reg + width_eff;
                    end else begin
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    if (cnt_reg == '0) begin
                        cnt_reg   <= cnt_reg + CW'(1);
                        state_reg <= last_reg ? ST_ORD : ST_IDLE;
                    end else begin
                        pos_reg   <= cnt_reg;
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    if (rdata > key) begin
                        if (pos_reg == CW'(1)) begin
                            state_reg <= ST_KEY0;
                        end else begin
                            pos_reg <= pos_reg - CW'(1);
                        end
                    end else begin
                        cnt_reg   <= cnt_reg + CW'(1);
                        state_reg <= last_reg ? ST_ORD : ST_IDLE;
                    end
                end
                ST_KEY0: begin
                    cnt_reg   <= cnt_reg + CW'(1);
                    state_reg <= last_reg ? ST_ORD : ST_IDLE;
                end
                ST_ORD: begin
                    state_reg <= ST_OCAP;
                end
                ST_OCAP: begin
                    // Hold the read until the result register is free.
                    if (!m_valid || m_ready) begin
                        m_valid        <= 1'b1;
                        m_sorted_value <= rdata[VW-1:0];
                        m_final_res    <= is_final;
                        m_overflow     <= flag_reg;
                        if (is_final) begin
                            cnt_reg   <= '0;
                            flag_reg  <= 1'b0;
                            state_reg <= ST_IDLE;
                        end else begin
                            o_reg     <= o_reg + AW'(1);
                            state_reg <= ST_ORD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_ITEMS))
        else $error("stored count exceeds capacity");

    a_walk_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (pos_reg != '0 && pos_reg <= cnt_reg))
        else $error("insertion walk out of range");

    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_OCAP))
        else $error("result raised outside readout");

    a_read_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OCAP) |-> ({1'b0, o_reg} < (AW+1)'(cnt_reg)))
        else $error("readout index past stored count");
endmodule
`default_nettype wire

// ===== dv/tb_bucket_sort_core.sv =====
// Testbench for the bucket sort core: random and directed value sets, scoreboard check.
`default_nettype none
module tb_bucket_sort_core;

    typedef struct packed {
        logic [bsort_pkg::VAL_W-1:0] value;
        logic                        last;
    } sort_item_t;

    typedef struct packed {
        logic [bsort_pkg::VAL_W-1:0] value;
        logic                        final_res;
        logic                        overflow;
    } sorted_res_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [bsort_pkg::PADDR_W-1:0]     paddr = '0;
    logic [31:0]                       pwdata = '0;
    logic [31:0]                       prdata;
    logic                              pready;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic [bsort_pkg::VAL_W-1:0]       s_value = '0;
    logic                              s_last = 1'b0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic [bsort_pkg::VAL_W-1:0]       m_sorted_value;
    logic                              m_final_res;
    logic                              m_overflow;

    bucket_sort_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_value(s_value), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_sorted_value(m_sorted_value),
        .m_final_res(m_final_res), .m_overflow(m_overflow)
    );

    always #4 aclk = ~aclk;

    localparam int WATCHDOG_LIMIT = 20000;

    // Predictor state: mirrors the core's store, bucket tags and config.
    logic [4:0]                  cfg_bcnt;
    logic [16:0]                 cfg_bwidth;
    logic [bsort_pkg::VAL_W-1:0] held_vals[bsort_pkg::MAX_ITEMS_DEF];
    int                          held_bkt[bsort_pkg::MAX_ITEMS_DEF];
    int                          held_n;
    bit                          drop_seen;

    sort_item_t  pending_items[$];
    sorted_res_t expected_sorted[$];
    int          mismatch_cnt = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          send_hold = 1'b0;
    bit          s_taken = 1'b0;

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        mismatch_cnt++;
    endtask

    function automatic int bucket_for(input logic [bsort_pkg::VAL_W-1:0] v);
        int nb;
        int w;
        int b;
        nb = (cfg_bcnt == 0) ? 1 : ((cfg_bcnt > bsort_pkg::MAX_BUCKETS_DEF) ?
                                    bsort_pkg::MAX_BUCKETS_DEF : int'(cfg_bcnt));
        w = (cfg_bwidth == 0) ? 1 : int'(cfg_bwidth);
        b = int'(v) / w;
        return (b > nb - 1) ? nb - 1 : b;
    endfunction

    // Store the value (or flag a drop); on last, emit the set bucket by bucket.
    task automatic predict_set(input sort_item_t it);
        int bucket_vals[$];
        int sorted_vals[$];
        sorted_res_t r;
        if (held_n < bsort_pkg::MAX_ITEMS_DEF) begin
            held_vals[held_n] = it.value;
            held_bkt[held_n] = bucket_for(it.value);
            held_n++;
        end else begin
            drop_seen = 1'b1;
        end
        if (!it.last) return;
        for (int b = 0; b < bsort_pkg::MAX_BUCKETS_DEF; b++) begin
            bucket_vals.delete();
            for (int i = 0; i < held_n; i++)
                if (held_bkt[i] == b) bucket_vals.push_back(int'(held_vals[i]));
            bucket_vals.sort();
            foreach (bucket_vals[k]) sorted_vals.push_back(bucket_vals[k]);
        end
        foreach (sorted_vals[k]) begin
            r.value = bsort_pkg::VAL_W'(sorted_vals[k]);
            r.final_res = (k == sorted_vals.size() - 1);
            r.overflow = drop_seen;
            expected_sorted.push_back(r);
        end
        held_n = 0;
        drop_seen = 1'b0;
    endtask

    // Driver: present the next pending transaction, hold it until accepted.
    always @(negedge aclk) begin
        if (s_valid && !s_taken) begin
            // hold the payload
        end else if (pending_items.size() > 0 && !send_hold &&
                     $urandom_range(99) >= send_idle_pct) begin
            s_valid <= 1'b1;
            s_value <= pending_items[0].value;
            s_last <= pending_items[0].last;
            predict_set(pending_items.pop_front());
        end else begin
            s_valid <= 1'b0;
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: check each result transaction against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn) begin
            s_taken <= s_valid && s_ready;
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                if (expected_sorted.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d", m_sorted_value));
                end else begin
                    sorted_res_t e;
                    e = expected_sorted.pop_front();
                    if (m_sorted_value !== e.value)
                        report_mismatch($sformatf("value %0d, want %0d",
                                                  m_sorted_value, e.value));
                    if (m_final_res !== e.final_res)
                        report_mismatch($sformatf("final_res %0b, want %0b",
                                                  m_final_res, e.final_res));
                    if (m_overflow !== e.overflow)
                        report_mismatch($sformatf("overflow %0b, want %0b",
                                                  m_overflow, e.overflow));
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("** bucket_sort_core: FAILED **");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [bsort_pkg::PADDR_W-1:0] addr,
                             input logic [31:0] data);
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Write both registers while idle; update the predictor copy too.
    task automatic set_config(input int bcnt, input int bwidth);
        apb_write(bsort_pkg::PADDR_W'(int'(bsort_pkg::REG_BCNT) * 4), 32'(bcnt));
        apb_write(bsort_pkg::PADDR_W'(int'(bsort_pkg::REG_BWIDTH) * 4), 32'(bwidth));
        cfg_bcnt = bcnt[4:0];
        cfg_bwidth = bwidth[16:0];
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_valid || expected_sorted.size() > 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic push_set(input int n, input int vmax);
        sort_item_t it;
        for (int i = 0; i < n; i++) begin
            it.value = bsort_pkg::VAL_W'($urandom_range(vmax));
            it.last = (i == n - 1);
            pending_items.push_back(it);
        end
    endtask

    initial begin
        sort_item_t it;
        cfg_bcnt = bsort_pkg::BCNT_RST;
        cfg_bwidth = bsort_pkg::BWIDTH_RST;
        held_n = 0;
        drop_seen = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, single-value set, duplicates, reset config.
        it = '{value: 17'd99999, last: 1'b0}; pending_items.push_back(it);
        it = '{value: 17'd0, last: 1'b0};     pending_items.push_back(it);
        it = '{value: 17'h1FFFF, last: 1'b0}; pending_items.push_back(it);
        it = '{value: 17'd6250, last: 1'b0};  pending_items.push_back(it);
        it = '{value: 17'd6249, last: 1'b0};  pending_items.push_back(it);
        it = '{value: 17'd6249, last: 1'b1};  pending_items.push_back(it);
        it = '{value: 17'd12345, last: 1'b1}; pending_items.push_back(it);
        drain();

        // Bucket count zero and width zero: one bucket of width one.
        set_config(0, 0);
        push_set(4, 131071);
        drain();
        // Bucket count above the maximum saturates; width at the top.
        set_config(31, 100000);
        push_set(5, 131071);
        drain();

        // Overflow: full store plus drops, the last one dropped too.
        set_config(16, 1);
        send_idle_pct = 0; recv_stall_pct = 0;
        push_set(bsort_pkg::MAX_ITEMS_DEF + 3, 131071);
        drain();

        // Random phases with changing configuration and idling.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            set_config($urandom_range(1, 16), $urandom_range(1, 100000));
            push_set($urandom_range(1, 4), 99999);
            push_set($urandom_range(1, 4), 131071);
            // Pause the sender with a set pending until all earlier results are out.
            while (pending_items.size() > 0 || s_valid)
                @(posedge aclk);
            send_hold = 1'b1;
            push_set($urandom_range(1, 4), 99999);
            while (expected_sorted.size() > 0)
                @(posedge aclk);
            send_hold = 1'b0;
            drain();
        end

        if (mismatch_cnt == 0 && expected_sorted.size() == 0) begin
            $display("** bucket_sort_core: PASSED **");
        end else begin
            $display("** bucket_sort_core: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
